// ===== rtl/core/cfb_pkg.sv =====
// Shared types and constants for the CRC-32 frame builder.
// Holds the command item passed from front to back and the byte-wise CRC step.
// No dependencies.
package cfb_pkg;

	localparam logic [31:0] FRAME_MAGIC = 32'hA5A5A5A5;
	localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES    = 32'hFFFFFFFF;

	// Configuration port geometry: byte addresses 4*i
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic        REG_MSG_TYPE = 1'b0;

	// One queued command: which sections to emit and the values they need
	typedef struct packed {
		logic        hdr;
		logic        dat;
		logic        trl;
		logic [7:0]  data;
		logic [31:0] len;
		logic [31:0] count;
		logic [7:0]  mtype;
	} cmd_t;

	// Advance a reflected CRC-32 by one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
		input logic [7:0] byte_in);
		logic [31:0] c;
		c = crc_in ^ {24'd0, byte_in};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/cfb_front.sv =====
// Front end of the frame builder: accepts input items and classifies them.
// Tracks the open frame and the message counter, emits commands as cfb_pkg::cmd_t.
// Depends on cfb_pkg.
module cfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic [31:0]       payload_len,
	input  logic              frame_first,
	input  logic              frame_last,
	input  logic [7:0]        msg_type,
	input  logic              q_full,
	output logic              q_push,
	output cfb_pkg::cmd_t     q_cmd
);

	logic        in_frame_q;
	logic [31:0] msg_count_q;
	logic        accept;
	logic        len_zero;

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign len_zero = (payload_len == 32'd0);

	// Classify the item into the sections it causes
	always_comb begin
		q_cmd.hdr   = frame_first;
		q_cmd.dat   = !(frame_first && len_zero);
		q_cmd.trl   = (frame_first && len_zero) || frame_last;
		q_cmd.data  = data_byte;
		q_cmd.len   = payload_len;
		q_cmd.count = msg_count_q + 32'd1;
		q_cmd.mtype = msg_type;
	end

	// Drop items that arrive outside a frame
	assign q_push = accept && (frame_first || in_frame_q);

	// Track frame state and message count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			msg_count_q <= 32'd0;
		end else if (accept) begin
			if (frame_first) begin
				msg_count_q <= msg_count_q + 32'd1;
				in_frame_q  <= !(len_zero || frame_last);
			end else if (in_frame_q && frame_last) begin
				in_frame_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/cfb_queue.sv =====
// Short command queue between front and back of the frame builder.
// Register-based FIFO of cfb_pkg::cmd_t entries, read at the head pointer.
// Depends on cfb_pkg.
module cfb_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  cfb_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output cfb_pkg::cmd_t rd_cmd,
	output logic          empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cfb_pkg::cmd_t   entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full   = (count_q == FULL_CNT);
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = entry_q[rd_ptr_q];

	// Store incoming commands
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/cfb_back.sv =====
// Back end of the frame builder: turns queued commands into output bytes.
// Sequences header, data and CRC trailer, keeps the running CRC, owns the output register.
// Depends on cfb_pkg.
module cfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  cfb_pkg::cmd_t q_head,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          frame_end
);

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_HDR   = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_TRL   = 2'd3;

	logic [1:0]  ph_q;
	logic [3:0]  cnt_q;
	logic [31:0] crc_q;
	logic        out_v_q;
	logic [7:0]  out_byte_q;
	logic        out_end_q;

	logic [1:0]  ph_eff;
	logic        out_rdy;
	logic        emit;
	logic [7:0]  byte_nxt;
	logic        end_nxt;
	logic [31:0] hdr_word;
	logic [31:0] trl_word;
	logic [31:0] crc_base;
	logic        cmd_done;

	assign out_rdy  = !out_v_q || pop;
	assign emit     = !q_empty && out_rdy;
	assign trl_word = ~crc_q;

	// Resolve the phase of a command that has not started yet
	always_comb begin
		ph_eff = ph_q;
		if (ph_q == PH_START) begin
			ph_eff = q_head.hdr ? PH_HDR : PH_DATA;
		end
	end

	// Pick the header word for the current header byte
	always_comb begin
		case (cnt_q[3:2])
			2'd0:    hdr_word = cfb_pkg::FRAME_MAGIC;
			2'd1:    hdr_word = q_head.count;
			2'd2:    hdr_word = {24'd0, q_head.mtype};
			2'd3:    hdr_word = q_head.len;
			default: hdr_word = 32'd0;
		endcase
	end

	// Select the next byte and the end flag
	always_comb begin
		end_nxt  = 1'b0;
		cmd_done = 1'b0;
		case (ph_eff)
			PH_HDR: begin
				byte_nxt = 8'(hdr_word >> {cnt_q[1:0], 3'b000});
			end
			PH_DATA: begin
				byte_nxt = q_head.data;
				cmd_done = !q_head.trl;
			end
			PH_TRL: begin
				byte_nxt = 8'(trl_word >> {cnt_q[1:0], 3'b000});
				end_nxt  = (cnt_q[1:0] == 2'd3);
				cmd_done = end_nxt;
			end
			default: begin
				byte_nxt = 8'd0;
			end
		endcase
	end

	assign q_pop    = emit && cmd_done;
	assign crc_base = (ph_eff == PH_HDR && cnt_q == 4'd0) ? cfb_pkg::CRC_ONES : crc_q;

	// Advance the sequencer and the running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_START;
			cnt_q <= 4'd0;
			crc_q <= cfb_pkg::CRC_ONES;
		end else if (emit) begin
			case (ph_eff)
				PH_HDR: begin
					crc_q <= cfb_pkg::crc_byte(crc_base, byte_nxt);
					if (cnt_q == 4'd15) begin
						cnt_q <= 4'd0;
						ph_q  <= q_head.dat ? PH_DATA : PH_TRL;
					end else begin
						cnt_q <= cnt_q + 4'd1;
						ph_q  <= PH_HDR;
					end
				end
				PH_DATA: begin
					crc_q <= cfb_pkg::crc_byte(crc_base, byte_nxt);
					cnt_q <= 4'd0;
					ph_q  <= q_head.trl ? PH_TRL : PH_START;
				end
				PH_TRL: begin
					if (end_nxt) begin
						cnt_q <= 4'd0;
						ph_q  <= PH_START;
						crc_q <= cfb_pkg::CRC_ONES;
					end else begin
						cnt_q <= cnt_q + 4'd1;
						ph_q  <= PH_TRL;
					end
				end
				default: begin
					ph_q <= PH_START;
				end
			endcase
		end
	end

	// Hold the output item until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_rdy) begin
			out_v_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_nxt;
			out_end_q  <= end_nxt;
		end
	end

	assign empty     = !out_v_q;
	assign out_byte  = out_byte_q;
	assign frame_end = out_end_q;

endmodule

// ===== rtl/core/crc32_frame_builder.sv =====
// Top level of the CRC-32 frame builder.
// Ties the configuration port, front end, command queue and back end together.
// Depends on cfb_pkg, cfb_front, cfb_queue and cfb_back.
//
// Usage:
//   Input channel: drive data_byte, payload_len, frame_first and frame_last with push;
//   an item is taken on an edge with push high and full low. A first item opens a frame,
//   later items carry payload bytes, frame_last closes it.
//   Result channel: while empty is low, out_byte and frame_end show the oldest byte of
//   the framed stream; pop takes it. frame_end marks the last CRC byte of a frame.
//   msg_type must be written over the APB-style port at byte address 0 only while the block is idle (user-enforced).
// Timing:
//   The first byte caused by an item passes through the command queue and the output register to the result ports.
//   Payload-only items flow at one item per cycle while pop keeps the output register free.
//   A first item makes the back end emit 16 header bytes, plus one data byte unless payload_len is zero,
//   and a last item adds 4 trailer bytes; the back end emits one byte per cycle while its output is taken,
//   so that byte sequencer sets the rate. The command queue absorbs up to QUEUE_DEPTH items while the back end
//   is busy, then full rises until a command is retired. When pop is held low the output register holds its byte,
//   the back end stops and the queue fills.
// Reset: clears the queue, output register, frame state and counter; msg_type returns to 1.
module crc32_frame_builder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cfb_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     data_byte,
	input  logic [31:0]                    payload_len,
	input  logic                           frame_first,
	input  logic                           frame_last,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     out_byte,
	output logic                           frame_end
);

	logic          [7:0] msg_type_q;
	logic                cfg_sel;
	logic                q_push;
	logic                q_full;
	logic                q_pop;
	logic                q_empty;
	cfb_pkg::cmd_t       q_in;
	cfb_pkg::cmd_t       q_head;

	// Configuration register
	assign pready  = 1'b1;
	assign cfg_sel = (paddr[2] == cfb_pkg::REG_MSG_TYPE);
	assign prdata  = cfg_sel ? {24'd0, msg_type_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_type_q <= 8'd1;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			msg_type_q <= pwdata[7:0];
		end
	end

	cfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.payload_len (payload_len),
		.frame_first (frame_first),
		.frame_last  (frame_last),
		.msg_type    (msg_type_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_in)
	);

	cfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_cmd (q_in),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_cmd (q_head),
		.empty  (q_empty)
	);

	cfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

	// The front never writes a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command written into full queue");

	// The back end only retires a command that is present
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command retired from empty queue");

	// Retiring a command with a trailer loads its end byte and frame_end into the output register
	a_end_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.trl) |=> (!empty && frame_end))
		else $error("frame end not shown after trailer command retired");

endmodule
